// ===== rtl/ucpb_pkg.sv =====
// shared types and constants for the unique colour palette builder
package ucpb_pkg;

	localparam int TABLE_DEPTH      = 4096;
	localparam int PALETTE_SIZE     = 256;
	localparam int TBL_AW           = $clog2(TABLE_DEPTH);
	localparam int CNT_W            = $clog2(TABLE_DEPTH + 1);
	localparam int SLOT_W           = $clog2(PALETTE_SIZE + 1);
	localparam int COLOR_W          = 8;
	localparam int RGB_W            = 3 * COLOR_W;
	localparam int PSLOT_W          = 8;
	localparam int QUEUE_DEPTH      = 2;
	localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
	localparam int APB_AW           = 3;
	localparam int APB_DW           = 32;
	localparam logic [PSLOT_W-1:0] FIRST_SLOT_RESET = PSLOT_W'(8);
	localparam logic [0:0] REG_FIRST_SLOT = 1'b0;

	typedef struct packed {
		logic [RGB_W-1:0] rgb;
		logic             last;
	} item_t;

	typedef struct packed {
		logic               load;
		logic [PSLOT_W-1:0] slot;
		logic [PSLOT_W-1:0] first_slot;
	} cfg_t;

	typedef struct packed {
		logic               done;
		logic               is_new;
		logic [CNT_W-1:0]   unique_count;
		logic               palette_write;
		logic [PSLOT_W-1:0] palette_slot;
		logic [RGB_W-1:0]   palette_rgb;
		logic [SLOT_W-1:0]  colors_allocated;
		logic               image_done;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'b01,
		ST_SEARCH = 2'b10
	} state_t;

endpackage

// ===== rtl/ucpb_ram.sv =====
// generic single-write, single-read ram with registered read data
module ucpb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ucpb_front.sv =====
// input capture: packs the pixel and holds it in a short queue for the search engine
module ucpb_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ucpb_pkg::COLOR_W-1:0] red,
	input  logic [ucpb_pkg::COLOR_W-1:0] green,
	input  logic [ucpb_pkg::COLOR_W-1:0] blue,
	input  logic                         last_pixel,
	output logic                         busy,
	output logic                         item_valid,
	output ucpb_pkg::item_t              item,
	input  logic                         item_pop
);

	ucpb_pkg::item_t                    mem_q [ucpb_pkg::QUEUE_DEPTH];
	logic [ucpb_pkg::QPTR_W-1:0]        wr_ptr_q;
	logic [ucpb_pkg::QPTR_W-1:0]        rd_ptr_q;
	logic [ucpb_pkg::QCNT_W-1:0]        count_q;
	logic                               push;
	logic                               pop;
	ucpb_pkg::item_t                    new_item;

	assign busy       = (count_q == ucpb_pkg::QCNT_W'(ucpb_pkg::QUEUE_DEPTH));
	assign item_valid = (count_q != '0);
	assign item       = mem_q[rd_ptr_q];
	assign push       = start && !busy;
	assign pop        = item_pop && item_valid;

	always_comb begin
		new_item.rgb  = {red, green, blue};
		new_item.last = last_pixel;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == ucpb_pkg::QPTR_W'(ucpb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == ucpb_pkg::QPTR_W'(ucpb_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/ucpb_back.sv =====
// search engine: scans the seen-colour table, stores new colours and assigns palette slots
module ucpb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  ucpb_pkg::item_t   item,
	output logic              item_pop,
	input  ucpb_pkg::cfg_t    cfg,
	output ucpb_pkg::result_t result
);

	ucpb_pkg::state_t                state_q;
	ucpb_pkg::item_t                 item_q;
	logic [ucpb_pkg::CNT_W-1:0]      idx_q;
	logic                            pend_q;
	logic [ucpb_pkg::CNT_W-1:0]      count_q;
	logic [ucpb_pkg::SLOT_W-1:0]     slot_q;
	logic                            done_q;
	ucpb_pkg::result_t               res_q;

	logic [ucpb_pkg::RGB_W-1:0]      rdata;
	logic                            hit;
	logic                            exhausted;
	logic                            searching;
	logic                            rd_en;
	logic                            decide;
	logic                            store;
	logic                            give;
	logic [ucpb_pkg::CNT_W-1:0]      count_nx;
	logic [ucpb_pkg::SLOT_W-1:0]     slot_nx;

	assign searching = (state_q == ucpb_pkg::ST_SEARCH);
	assign hit       = pend_q && (rdata == item_q.rgb);
	assign exhausted = (idx_q == count_q);
	assign rd_en     = searching && !hit && !exhausted;
	assign decide    = searching && (hit || exhausted);
	assign store     = !hit && (count_q < ucpb_pkg::CNT_W'(ucpb_pkg::TABLE_DEPTH));
	assign give      = !hit && (slot_q < ucpb_pkg::SLOT_W'(ucpb_pkg::PALETTE_SIZE));
	assign count_nx  = count_q + ucpb_pkg::CNT_W'(store);
	assign slot_nx   = slot_q + ucpb_pkg::SLOT_W'(give);
	assign item_pop  = (state_q == ucpb_pkg::ST_IDLE) && item_valid;

	ucpb_ram #(
		.WIDTH(ucpb_pkg::RGB_W),
		.DEPTH(ucpb_pkg::TABLE_DEPTH)
	) u_seen (
		.clk   (clk),
		.we    (decide && store),
		.waddr (count_q[ucpb_pkg::TBL_AW-1:0]),
		.wdata (item_q.rgb),
		.re    (rd_en),
		.raddr (idx_q[ucpb_pkg::TBL_AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ucpb_pkg::ST_IDLE;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
			slot_q  <= ucpb_pkg::SLOT_W'(ucpb_pkg::FIRST_SLOT_RESET);
			done_q  <= 1'b0;
		end else begin
			done_q <= decide;
			case (state_q)
				ucpb_pkg::ST_IDLE: begin
					if (item_valid) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= ucpb_pkg::ST_SEARCH;
					end
				end
				ucpb_pkg::ST_SEARCH: begin
					pend_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (decide) begin
						state_q <= ucpb_pkg::ST_IDLE;
						if (item_q.last) begin
							count_q <= '0;
							slot_q  <= ucpb_pkg::SLOT_W'(cfg.first_slot);
						end else begin
							count_q <= count_nx;
							slot_q  <= slot_nx;
						end
					end
				end
				default: begin
					state_q <= ucpb_pkg::ST_IDLE;
				end
			endcase
			if (cfg.load) begin
				slot_q <= ucpb_pkg::SLOT_W'(cfg.slot);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_q <= item;
		end
		if (decide) begin
			res_q.done             <= 1'b1;
			res_q.is_new           <= !hit;
			res_q.unique_count     <= count_nx;
			res_q.palette_write    <= give;
			res_q.palette_slot     <= give ? slot_q[ucpb_pkg::PSLOT_W-1:0] : '0;
			res_q.palette_rgb      <= give ? item_q.rgb : '0;
			res_q.colors_allocated <= slot_nx;
			res_q.image_done       <= item_q.last;
		end
	end

	always_comb begin
		result      = res_q;
		result.done = done_q;
	end

endmodule

// ===== rtl/unique_color_palette_builder.sv =====
// top level: apb register, input queue and table search engine
// One pixel is taken per transfer when start is high and busy is low; up to two pixels wait in
// the input queue, and busy rises when it is full. The engine scans the seen-colour table one
// entry per cycle through a single ram read port, so a miss scans every stored entry while a
// hit ends the scan as soon as the matching colour is read back from the ram. Each result is
// shown for one cycle with done high and cannot be held off by the receiver. first_palette_slot
// sits at byte address 0 and also reloads the slot counter at once; write it only while idle.
module unique_color_palette_builder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ucpb_pkg::APB_AW-1:0]          paddr,
	input  logic [ucpb_pkg::APB_DW-1:0]          pwdata,
	output logic [ucpb_pkg::APB_DW-1:0]          prdata,
	output logic                                 pready,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [ucpb_pkg::COLOR_W-1:0]         red,
	input  logic [ucpb_pkg::COLOR_W-1:0]         green,
	input  logic [ucpb_pkg::COLOR_W-1:0]         blue,
	input  logic                                 last_pixel,
	output logic                                 done,
	output logic                                 is_new,
	output logic [ucpb_pkg::CNT_W-1:0]           unique_count,
	output logic                                 palette_write,
	output logic [ucpb_pkg::PSLOT_W-1:0]         palette_slot,
	output logic [ucpb_pkg::RGB_W-1:0]           palette_rgb,
	output logic [ucpb_pkg::SLOT_W-1:0]          colors_allocated,
	output logic                                 image_done
);

	logic [ucpb_pkg::PSLOT_W-1:0] first_slot_q;
	logic                         reg_sel;
	logic                         cfg_wr;
	logic                         item_valid;
	logic                         item_pop;
	ucpb_pkg::item_t              item;
	ucpb_pkg::cfg_t               cfg;
	ucpb_pkg::result_t            result;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ucpb_pkg::APB_AW-1:2] == ucpb_pkg::REG_FIRST_SLOT);
	assign cfg_wr  = psel && penable && pwrite && reg_sel;
	assign prdata  = reg_sel ? ucpb_pkg::APB_DW'(first_slot_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_slot_q <= ucpb_pkg::FIRST_SLOT_RESET;
		end else if (cfg_wr) begin
			first_slot_q <= pwdata[ucpb_pkg::PSLOT_W-1:0];
		end
	end

	always_comb begin
		cfg.load       = cfg_wr;
		cfg.slot       = pwdata[ucpb_pkg::PSLOT_W-1:0];
		cfg.first_slot = first_slot_q;
	end

	ucpb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.last_pixel (last_pixel),
		.busy       (busy),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	ucpb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.cfg        (cfg),
		.result     (result)
	);

	assign done             = result.done;
	assign is_new           = result.is_new;
	assign unique_count     = result.unique_count;
	assign palette_write    = result.palette_write;
	assign palette_slot     = result.palette_slot;
	assign palette_rgb      = result.palette_rgb;
	assign colors_allocated = result.colors_allocated;
	assign image_done       = result.image_done;

endmodule

// ===== verif/ucpb_checker.sv =====
// checker: predicts each pixel's result from its own colour table and compares it with the output
`timescale 1ns / 100ps
module ucpb_checker
	import ucpb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	input  logic                pready,
	input  logic                start,
	input  logic                busy,
	input  logic [COLOR_W-1:0]  red,
	input  logic [COLOR_W-1:0]  green,
	input  logic [COLOR_W-1:0]  blue,
	input  logic                last_pixel,
	input  logic                done,
	input  logic                is_new,
	input  logic [CNT_W-1:0]    unique_count,
	input  logic                palette_write,
	input  logic [PSLOT_W-1:0]  palette_slot,
	input  logic [RGB_W-1:0]    palette_rgb,
	input  logic [SLOT_W-1:0]   colors_allocated,
	input  logic                image_done,
	output int                  mismatches,
	output int                  outstanding,
	output int                  results_checked
);

	localparam logic [APB_AW-1:0] ADDR_FIRST_SLOT = APB_AW'(4 * REG_FIRST_SLOT);

	typedef struct packed {
		logic               is_new;
		logic [CNT_W-1:0]   count;
		logic               wr;
		logic [PSLOT_W-1:0] slot;
		logic [RGB_W-1:0]   rgb;
		logic [SLOT_W-1:0]  alloc;
		logic               img_done;
	} pixel_result_t;

	bit                 seen_rgb [logic [RGB_W-1:0]];
	int                 stored;
	logic [PSLOT_W-1:0] first_slot;
	logic [SLOT_W-1:0]  next_slot;
	pixel_result_t      expected_pixels [$];

	function automatic pixel_result_t classify_pixel(input logic [RGB_W-1:0] rgb,
		input logic lst);
		pixel_result_t res;
		res = '0;
		if (!seen_rgb.exists(rgb)) begin
			res.is_new = 1'b1;
			// full table: reported new but not stored
			if (stored < TABLE_DEPTH) begin
				seen_rgb[rgb] = 1'b1;
				stored++;
			end
			if (next_slot < SLOT_W'(PALETTE_SIZE)) begin
				res.wr = 1'b1;
				res.slot = next_slot[PSLOT_W-1:0];
				res.rgb = rgb;
				next_slot++;
			end
		end
		res.count = CNT_W'(stored);
		res.alloc = next_slot;
		res.img_done = lst;
		if (lst) begin
			seen_rgb.delete();
			stored = 0;
			next_slot = SLOT_W'(first_slot);
		end
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		pixel_result_t want;
		if (!arst_n) begin
			seen_rgb.delete();
			stored = 0;
			first_slot = FIRST_SLOT_RESET;
			next_slot = SLOT_W'(FIRST_SLOT_RESET);
			expected_pixels.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (expected_pixels.size() == 0) begin
					mismatches++;
					$display("%0t ns: result mismatch, expected none, actual rgb %0h",
						$time, palette_rgb);
				end else begin
					want = expected_pixels.pop_front();
					results_checked++;
					check_field("is_new", want.is_new, is_new);
					check_field("unique_count", want.count, unique_count);
					check_field("palette_write", want.wr, palette_write);
					check_field("palette_slot", want.slot, palette_slot);
					check_field("palette_rgb", want.rgb, palette_rgb);
					check_field("colors_allocated", want.alloc, colors_allocated);
					check_field("image_done", want.img_done, image_done);
				end
			end
			// register write reloads the slot counter, table untouched
			if (psel && penable && pwrite && pready && paddr == ADDR_FIRST_SLOT) begin
				first_slot = pwdata[PSLOT_W-1:0];
				next_slot = SLOT_W'(first_slot);
			end
			if (start && !busy)
				expected_pixels.push_back(classify_pixel({red, green, blue}, last_pixel));
			outstanding <= expected_pixels.size();
		end
	end

endmodule

// ===== verif/tb.sv =====
// testbench top: clock, reset, pixel and register stimulus, and the verdict
`timescale 1ns / 100ps
module tb;
	import ucpb_pkg::*;

	localparam int RANDOM_PIXELS = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam logic [APB_AW-1:0] ADDR_FIRST_SLOT = APB_AW'(4 * REG_FIRST_SLOT);

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [APB_AW-1:0]  paddr;
	logic [APB_DW-1:0]  pwdata;
	logic [APB_DW-1:0]  prdata;
	logic               pready;
	logic               start;
	logic               busy;
	logic [COLOR_W-1:0] red;
	logic [COLOR_W-1:0] green;
	logic [COLOR_W-1:0] blue;
	logic               last_pixel;
	logic               done;
	logic               is_new;
	logic [CNT_W-1:0]   unique_count;
	logic               palette_write;
	logic [PSLOT_W-1:0] palette_slot;
	logic [RGB_W-1:0]   palette_rgb;
	logic [SLOT_W-1:0]  colors_allocated;
	logic               image_done;

	int mismatches;
	int outstanding;
	int results_checked;
	int cycles;
	int pixels_sent;
	int images_sent;
	int slot_settings;
	int burst_left;

	unique_color_palette_builder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.red(red),
		.green(green),
		.blue(blue),
		.last_pixel(last_pixel),
		.done(done),
		.is_new(is_new),
		.unique_count(unique_count),
		.palette_write(palette_write),
		.palette_slot(palette_slot),
		.palette_rgb(palette_rgb),
		.colors_allocated(colors_allocated),
		.image_done(image_done)
	);

	ucpb_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.red(red),
		.green(green),
		.blue(blue),
		.last_pixel(last_pixel),
		.done(done),
		.is_new(is_new),
		.unique_count(unique_count),
		.palette_write(palette_write),
		.palette_slot(palette_slot),
		.palette_rgb(palette_rgb),
		.colors_allocated(colors_allocated),
		.image_done(image_done),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_checked(results_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL unique_color_palette_builder");
			$finish;
		end
	end

	task automatic send_pixel(input logic [RGB_W-1:0] rgb, input logic lst);
		start <= 1'b1;
		{red, green, blue} <= rgb;
		last_pixel <= lst;
		@(posedge clk);
		while (busy) @(posedge clk);
		pixels_sent++;
		if (lst)
			images_sent++;
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 5);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_first_slot(input logic [PSLOT_W-1:0] slot);
		settle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_FIRST_SLOT;
		pwdata <= APB_DW'(slot);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		slot_settings++;
	endtask

	task automatic run_image(input int len, input bit close);
		logic [RGB_W-1:0] pool [6];
		logic [RGB_W-1:0] rgb;
		foreach (pool[i])
			pool[i] = RGB_W'($urandom);
		for (int n = 0; n < len; n++) begin
			case ($urandom_range(0, 9))
				0: begin
					rgb = $urandom_range(0, 1) ? '1 : '0;
				end
				1, 2: begin
					rgb = RGB_W'($urandom);
				end
				default: begin
					rgb = pool[$urandom_range(0, 5)];
				end
			endcase
			send_pixel(rgb, close && n == len - 1);
			pace();
		end
	endtask

	initial begin : stimulus
		int random_base;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		red = '0;
		green = '0;
		blue = '0;
		last_pixel = 1'b0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting: extremes, hits, single-pixel image
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hFFFFFF, 1'b0);
		send_pixel(24'h000000, 1'b0);
		send_pixel(24'hAA55AA, 1'b0);
		send_pixel(24'h55AA55, 1'b0);
		send_pixel(24'hFFFFFF, 1'b1);
		send_pixel(24'hFFFFFF, 1'b1);

		// palette fills up
		write_first_slot(8'd254);
		send_pixel(24'h123456, 1'b0);
		send_pixel(24'h654321, 1'b0);
		send_pixel(24'h0F0F0F, 1'b0);
		send_pixel(24'h123456, 1'b0);

		// reload mid image, table kept
		write_first_slot(8'd0);
		send_pixel(24'h654321, 1'b0);
		send_pixel(24'hF0F0F0, 1'b0);
		send_pixel(24'h0F0F0F, 1'b1);

		write_first_slot(8'd255);
		send_pixel(24'h800000, 1'b0);
		send_pixel(24'h008000, 1'b0);
		send_pixel(24'h000080, 1'b1);
		send_pixel(24'h010101, 1'b1);

		random_base = pixels_sent;
		while (pixels_sent - random_base < RANDOM_PIXELS) begin
			case ($urandom_range(0, 3))
				0: write_first_slot(8'd0);
				1: write_first_slot(8'd255);
				2: write_first_slot(PSLOT_W'($urandom_range(240, 254)));
				default: write_first_slot(PSLOT_W'($urandom_range(0, 255)));
			endcase
			repeat ($urandom_range(1, 3))
				run_image(($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 24),
					$urandom_range(0, 3) != 0);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d pixels in %0d closed images over %0d first-slot settings",
			pixels_sent, images_sent, slot_settings + 1);
		$display("%0d results checked field by field", results_checked);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS unique_color_palette_builder");
		end else begin
			$display("FAIL unique_color_palette_builder");
		end
		$finish;
	end

endmodule
